>>> design/obb_pkg.sv
// Shared widths, types and fixed-point helpers for the box overlap pipeline.
package obb_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int AXIS_FRAC_BITS = 14;

  localparam int AXIS_W   = AXIS_FRAC_BITS + 2;
  localparam int SIZE_W   = COORD_WIDTH - 1;
  localparam int HALF_W   = COORD_WIDTH - 2;
  // centre offset needs one bit more than a coordinate
  localparam int OP_W     = COORD_WIDTH + 1;
  localparam int PROD_W   = OP_W + AXIS_W;
  localparam int TR_W     = PROD_W - AXIS_FRAC_BITS;
  localparam int DOT_W    = TR_W + 1;
  localparam int LIM_W    = TR_W + 2;
  localparam int NUM_AXES = 4;

  // axes 1 and 3 are local y axes (-sin, cos): x term enters negated
  localparam logic [NUM_AXES-1:0] AXIS_NEG_X = 4'b1010;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]      axis_t;
  typedef logic        [SIZE_W-1:0]      size_t;
  typedef logic        [HALF_W-1:0]      half_t;
  typedef logic signed [OP_W-1:0]        op_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [TR_W-1:0]        tr_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic        [TR_W-1:0]        mag_t;
  typedef logic        [LIM_W-1:0]       lim_t;

  // drop the axis fraction bits, rounding toward zero
  function automatic tr_t trunc_q(input prod_t p);
    prod_t bias;
    prod_t adj;
    bias = '0;
    bias[AXIS_FRAC_BITS-1:0] = {AXIS_FRAC_BITS{p[PROD_W-1]}};
    adj = p + bias;
    return adj[PROD_W-1:AXIS_FRAC_BITS];
  endfunction

  // |(+/-x) + y|
  function automatic mag_t dot_abs(input tr_t x, input tr_t y, input logic neg_x);
    dot_t xe;
    dot_t ye;
    dot_t d;
    xe = dot_t'(x);
    ye = dot_t'(y);
    d  = neg_x ? ye - xe : ye + xe;
    return d[DOT_W-1] ? mag_t'(-d) : mag_t'(d);
  endfunction

endpackage

>>> design/obb_box_if.sv
// Input channel: one pair of oriented boxes per word.
interface obb_box_if;
  import obb_pkg::*;

  logic   valid;
  logic   ready;
  coord_t center_a_x;
  coord_t center_a_y;
  axis_t  dir_a_cos;
  axis_t  dir_a_sin;
  size_t  width_a;
  size_t  height_a;
  coord_t center_b_x;
  coord_t center_b_y;
  axis_t  dir_b_cos;
  axis_t  dir_b_sin;
  size_t  width_b;
  size_t  height_b;

  modport source (
    output valid, center_a_x, center_a_y, dir_a_cos, dir_a_sin, width_a, height_a,
    output center_b_x, center_b_y, dir_b_cos, dir_b_sin, width_b, height_b,
    input  ready
  );

  modport sink (
    input  valid, center_a_x, center_a_y, dir_a_cos, dir_a_sin, width_a, height_a,
    input  center_b_x, center_b_y, dir_b_cos, dir_b_sin, width_b, height_b,
    output ready
  );

endinterface

>>> design/obb_res_if.sv
// Output channel: one overlap flag per word.
interface obb_res_if;

  logic valid;
  logic ready;
  logic overlapping;

  modport source (output valid, overlapping, input ready);
  modport sink (input valid, overlapping, output ready);

endinterface

>>> design/obb_mul_reg.sv
// Signed coordinate-by-axis multiplier with registered full product.
module obb_mul_reg (
  input  logic          clk,
  input  logic          en,
  input  obb_pkg::op_t   a,
  input  obb_pkg::axis_t b,
  output obb_pkg::prod_t p
);
  import obb_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod_t'(a) * prod_t'(b);
    end
  end

endmodule

>>> design/obb_overlap_test_2d.sv
// Top level: pipelined separating-axis overlap test for two 2D oriented boxes.
//
//   port     dir  handshake     word
//   boxes    in   valid/ready   two boxes: centres, x axes, full sizes
//   result   out  valid/ready   overlapping flag
//
// One word per cycle unless the result side stalls; a result passes every stage register after its word is taken.
// Stages: offset + edge products, edge rounding, 24 projection products,
// dot sums and magnitudes, limit sum and compare into the output register.
// Reset clears the stage valid bits only.
// A stage loads when it is empty or its successor loads, so a stalled result
// still lets earlier stages fill their bubbles; nothing is dropped or repeated.
module obb_overlap_test_2d (
  input  logic clk,
  input  logic rst,
  obb_box_if.sink   boxes,
  obb_res_if.source result
);
  import obb_pkg::*;

  localparam int NUM_EDGE = 8;
  localparam int NUM_DOT  = NUM_AXES * 6;

  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !v5 || result.ready;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign boxes.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= boxes.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // ---------------- stage 1: offset, halves, edge products
  half_t in_wa, in_ha, in_wb, in_hb;
  op_t   ed_op [NUM_EDGE];
  axis_t ed_ax [NUM_EDGE];
  prod_t ed_prod [NUM_EDGE];

  assign in_wa = boxes.width_a[SIZE_W-1:1];
  assign in_ha = boxes.height_a[SIZE_W-1:1];
  assign in_wb = boxes.width_b[SIZE_W-1:1];
  assign in_hb = boxes.height_b[SIZE_W-1:1];

  // half width * (cos, sin), half height * (sin, cos); y-axis x term negated later
  always_comb begin
    ed_op[0] = op_t'(in_wa); ed_ax[0] = boxes.dir_a_cos;
    ed_op[1] = op_t'(in_wa); ed_ax[1] = boxes.dir_a_sin;
    ed_op[2] = op_t'(in_ha); ed_ax[2] = boxes.dir_a_sin;
    ed_op[3] = op_t'(in_ha); ed_ax[3] = boxes.dir_a_cos;
    ed_op[4] = op_t'(in_wb); ed_ax[4] = boxes.dir_b_cos;
    ed_op[5] = op_t'(in_wb); ed_ax[5] = boxes.dir_b_sin;
    ed_op[6] = op_t'(in_hb); ed_ax[6] = boxes.dir_b_sin;
    ed_op[7] = op_t'(in_hb); ed_ax[7] = boxes.dir_b_cos;
  end

  for (genvar i = 0; i < NUM_EDGE; i++) begin : g_edge_mul
    obb_mul_reg u_mul (
      .clk (clk),
      .en  (adv1),
      .a   (ed_op[i]),
      .b   (ed_ax[i]),
      .p   (ed_prod[i])
    );
  end

  op_t   t1x, t1y;
  axis_t ac1, as1, bc1, bs1;
  half_t wa1, ha1, wb1, hb1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      t1x <= op_t'(boxes.center_b_x) - op_t'(boxes.center_a_x);
      t1y <= op_t'(boxes.center_b_y) - op_t'(boxes.center_a_y);
      ac1 <= boxes.dir_a_cos;
      as1 <= boxes.dir_a_sin;
      bc1 <= boxes.dir_b_cos;
      bs1 <= boxes.dir_b_sin;
      wa1 <= in_wa;
      ha1 <= in_ha;
      wb1 <= in_wb;
      hb1 <= in_hb;
    end
  end

  // ---------------- stage 2: rounded edge vectors
  op_t edge_next [NUM_EDGE];

  always_comb begin
    tr_t tr;
    for (int j = 0; j < NUM_EDGE; j++) begin
      tr = trunc_q(ed_prod[j]);
      // x of the scaled local y axis is -half_height * sin
      if (j == 2 || j == 6) tr = -tr;
      edge_next[j] = op_t'(tr);
    end
  end

  op_t   t2x, t2y;
  axis_t ac2, as2, bc2, bs2;
  half_t wa2, ha2, wb2, hb2;
  op_t   edge2 [NUM_EDGE];

  always_ff @(posedge clk) begin
    if (adv2) begin
      t2x <= t1x;
      t2y <= t1y;
      ac2 <= ac1;
      as2 <= as1;
      bc2 <= bc1;
      bs2 <= bs1;
      wa2 <= wa1;
      ha2 <= ha1;
      wb2 <= wb1;
      hb2 <= hb1;
      for (int j = 0; j < NUM_EDGE; j++) edge2[j] <= edge_next[j];
    end
  end

  // ---------------- stage 3: projection products
  // per axis: offset x/y, then x/y of the other box's width edge and height edge
  op_t   dop   [NUM_DOT];
  axis_t dax   [NUM_DOT];
  prod_t dprod [NUM_DOT];

  always_comb begin
    axis_t      ux;
    axis_t      uy;
    logic [2:0] base;
    for (int k = 0; k < NUM_AXES; k++) begin
      ux = (k == 0) ? ac2 : (k == 1) ? as2 : (k == 2) ? bc2 : bs2;
      uy = (k == 0) ? as2 : (k == 1) ? ac2 : (k == 2) ? bs2 : bc2;
      // A's axes see B's edges and the other way round
      base = (k < 2) ? 3'd4 : 3'd0;
      dop[k*6+0] = t2x;                 dax[k*6+0] = ux;
      dop[k*6+1] = t2y;                 dax[k*6+1] = uy;
      dop[k*6+2] = edge2[base];         dax[k*6+2] = ux;
      dop[k*6+3] = edge2[base + 3'd1];  dax[k*6+3] = uy;
      dop[k*6+4] = edge2[base + 3'd2];  dax[k*6+4] = ux;
      dop[k*6+5] = edge2[base + 3'd3];  dax[k*6+5] = uy;
    end
  end

  for (genvar i = 0; i < NUM_DOT; i++) begin : g_dot_mul
    obb_mul_reg u_mul (
      .clk (clk),
      .en  (adv3),
      .a   (dop[i]),
      .b   (dax[i]),
      .p   (dprod[i])
    );
  end

  half_t own3 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (adv3) begin
      own3[0] <= wa2;
      own3[1] <= ha2;
      own3[2] <= wb2;
      own3[3] <= hb2;
    end
  end

  // ---------------- stage 4: dot sums and magnitudes
  mag_t proj_next [NUM_AXES];
  mag_t ea_next   [NUM_AXES];
  mag_t fa_next   [NUM_AXES];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      proj_next[k] = dot_abs(trunc_q(dprod[k*6+0]), trunc_q(dprod[k*6+1]), AXIS_NEG_X[k]);
      ea_next[k]   = dot_abs(trunc_q(dprod[k*6+2]), trunc_q(dprod[k*6+3]), AXIS_NEG_X[k]);
      fa_next[k]   = dot_abs(trunc_q(dprod[k*6+4]), trunc_q(dprod[k*6+5]), AXIS_NEG_X[k]);
    end
  end

  mag_t  proj4 [NUM_AXES];
  mag_t  ea4   [NUM_AXES];
  mag_t  fa4   [NUM_AXES];
  half_t own4  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (adv4) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        proj4[k] <= proj_next[k];
        ea4[k]   <= ea_next[k];
        fa4[k]   <= fa_next[k];
        own4[k]  <= own3[k];
      end
    end
  end

  // ---------------- stage 5: limit and compare; equality still overlaps
  logic ov_next;

  always_comb begin
    lim_t lim;
    ov_next = 1'b1;
    for (int k = 0; k < NUM_AXES; k++) begin
      lim = lim_t'(own4[k]) + lim_t'(ea4[k]) + lim_t'(fa4[k]);
      if (lim_t'(proj4[k]) > lim) ov_next = 1'b0;
    end
  end

  logic ov5;

  always_ff @(posedge clk) begin
    if (adv5) begin
      ov5 <= ov_next;
    end
  end

  assign result.valid       = v5;
  assign result.overlapping = ov5;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) !v1 |-> boxes.ready)
    else $error("input stalled with empty first stage");
  assert property (@(posedge clk) disable iff (rst) (boxes.valid && boxes.ready) |=> v1)
    else $error("accepted word missing from first stage");
  assert property (@(posedge clk) disable iff (rst) (v2 && !adv2) |=> v2)
    else $error("stalled word lost in stage 2");
  assert property (@(posedge clk) disable iff (rst) (v4 && adv5) |=> result.valid)
    else $error("word lost entering output register");
  assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> bench/tb_obb_overlap_test_2d.sv
// Testbench for obb_overlap_test_2d: directed and random box pairs checked against a fixed-point predictor.
module tb_obb_overlap_test_2d;
  import obb_pkg::*;

  localparam int     ONE_Q16   = 1 << 16;
  localparam int     AXIS_ONE  = 1 << AXIS_FRAC_BITS;
  localparam int     N_RANDOM  = 630;
  localparam longint SAT_MAG   = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam int     SIZE_MAX  = 32'sh7FFF_FFFF;
  localparam int     AX_MAX    = 32767;
  localparam int     AX_MIN    = -32768;

  typedef struct {
    coord_t center_a_x;
    coord_t center_a_y;
    axis_t  dir_a_cos;
    axis_t  dir_a_sin;
    size_t  width_a;
    size_t  height_a;
    coord_t center_b_x;
    coord_t center_b_y;
    axis_t  dir_b_cos;
    axis_t  dir_b_sin;
    size_t  width_b;
    size_t  height_b;
  } box_pair_t;

  class overlap_scoreboard;
    bit          overlap_due[$];
    int unsigned checked;
    int unsigned errors;

    function longint clamp_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (s > SAT_MAG) return SAT_MAG;
      if (s < -SAT_MAG) return -SAT_MAG;
      return s;
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // exact product, fraction dropped toward zero, magnitude saturated
    function longint scale_axis(longint v, longint ax);
      logic [127:0] mv;
      logic [127:0] ma;
      logic [127:0] prod;
      bit           neg;
      neg  = (v < 0) != (ax < 0);
      mv   = 128'(magnitude(v));
      ma   = 128'(magnitude(ax));
      prod = (mv * ma) >> AXIS_FRAC_BITS;
      if (prod > 128'(SAT_MAG)) prod = 128'(SAT_MAG);
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function longint axis_dot(longint vx, longint vy, longint ux, longint uy);
      return clamp_sum(scale_axis(vx, ux), scale_axis(vy, uy));
    endfunction

    function bit splits(longint tx, longint ty, longint ux, longint uy, longint own,
                        longint ex, longint ey, longint fx, longint fy);
      longint gap;
      longint reach;
      gap   = magnitude(axis_dot(tx, ty, ux, uy));
      reach = clamp_sum(own, magnitude(axis_dot(ex, ey, ux, uy)));
      reach = clamp_sum(reach, magnitude(axis_dot(fx, fy, ux, uy)));
      return gap > reach;
    endfunction

    function bit predict_overlap(box_pair_t p);
      longint tx, ty, ac, an, bc, bn, wa, ha, wb, hb;
      longint wax, way, hax, hay, wbx, wby, hbx, hby;
      bit     sep;
      tx  = longint'(p.center_b_x) - longint'(p.center_a_x);
      ty  = longint'(p.center_b_y) - longint'(p.center_a_y);
      ac  = longint'(p.dir_a_cos);
      an  = longint'(p.dir_a_sin);
      bc  = longint'(p.dir_b_cos);
      bn  = longint'(p.dir_b_sin);
      wa  = longint'(p.width_a >> 1);
      ha  = longint'(p.height_a >> 1);
      wb  = longint'(p.width_b >> 1);
      hb  = longint'(p.height_b >> 1);
      wax = scale_axis(wa, ac);
      way = scale_axis(wa, an);
      hax = scale_axis(ha, -an);
      hay = scale_axis(ha, ac);
      wbx = scale_axis(wb, bc);
      wby = scale_axis(wb, bn);
      hbx = scale_axis(hb, -bn);
      hby = scale_axis(hb, bc);
      sep = splits(tx, ty, ac, an, wa, wbx, wby, hbx, hby)
         || splits(tx, ty, -an, ac, ha, wbx, wby, hbx, hby)
         || splits(tx, ty, bc, bn, wb, wax, way, hax, hay)
         || splits(tx, ty, -bn, bc, hb, wax, way, hax, hay);
      return !sep;
    endfunction

    function void note_pair(box_pair_t p);
      overlap_due.push_back(predict_overlap(p));
    endfunction

    function void check_result(logic got);
      bit want;
      if (overlap_due.size() == 0) begin
        $error("overlapping: word with nothing pending, actual %0b", got);
        errors++;
        return;
      end
      want = overlap_due.pop_front();
      checked++;
      if (got !== want) begin
        $error("overlapping mismatch: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  obb_box_if boxes();
  obb_res_if result();

  obb_overlap_test_2d uut (
    .clk    (clk),
    .rst    (rst),
    .boxes  (boxes),
    .result (result)
  );

  overlap_scoreboard sb;
  int unsigned       pairs_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("** obb_overlap_test_2d: FAILED **");
    $finish;
  end

  // mostly short, now and then long
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic box_pair_t mk_pair(int ax, int ay, int ac, int an,
                                        int wa, int ha, int bx, int by,
                                        int bc, int bn, int wb, int hb);
    box_pair_t p;
    p.center_a_x = coord_t'(ax);  p.center_a_y = coord_t'(ay);
    p.dir_a_cos  = axis_t'(ac);   p.dir_a_sin  = axis_t'(an);
    p.width_a    = size_t'(wa);   p.height_a   = size_t'(ha);
    p.center_b_x = coord_t'(bx);  p.center_b_y = coord_t'(by);
    p.dir_b_cos  = axis_t'(bc);   p.dir_b_sin  = axis_t'(bn);
    p.width_b    = size_t'(wb);   p.height_b   = size_t'(hb);
    return p;
  endfunction

  function automatic void unit_axis(output int c, output int s);
    real ang;
    ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
    c   = $rtoi($cos(ang) * AXIS_ONE);
    s   = $rtoi($sin(ang) * AXIS_ONE);
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 1 << 25)) - (1 << 24);
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t p;
    int        ac, an, bc, bn;
    int        ax, ay, dx, dy, kind;
    int        wa, ha, wb, hb;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // neighbors at random angles: both outcomes are common
      unit_axis(ac, an);
      unit_axis(bc, bn);
      ax = near_coord();
      ay = near_coord();
      dx = int'($urandom_range(0, 50 * ONE_Q16)) - 25 * ONE_Q16;
      dy = int'($urandom_range(0, 50 * ONE_Q16)) - 25 * ONE_Q16;
      p = mk_pair(ax, ay, ac, an, $urandom_range(0, 20 * ONE_Q16),
                  $urandom_range(0, 20 * ONE_Q16), ax + dx, ay + dy, bc, bn,
                  $urandom_range(0, 20 * ONE_Q16), $urandom_range(0, 20 * ONE_Q16));
    end else if (kind < 65) begin
      // aligned boxes at contact, one lsb inside or one lsb apart
      wa = $urandom_range(0, 8 * ONE_Q16);
      ha = $urandom_range(0, 8 * ONE_Q16);
      wb = $urandom_range(0, 8 * ONE_Q16);
      hb = $urandom_range(0, 8 * ONE_Q16);
      ac = $urandom_range(0, 1) ? AXIS_ONE : -AXIS_ONE;
      bc = $urandom_range(0, 1) ? AXIS_ONE : -AXIS_ONE;
      ax = near_coord();
      ay = near_coord();
      if ($urandom_range(0, 1)) begin
        dx = int'(wa >> 1) + int'(wb >> 1) + int'($urandom_range(0, 2)) - 1;
        dy = int'($urandom_range(0, ONE_Q16)) - ONE_Q16 / 2;
      end else begin
        dy = int'(ha >> 1) + int'(hb >> 1) + int'($urandom_range(0, 2)) - 1;
        dx = int'($urandom_range(0, ONE_Q16)) - ONE_Q16 / 2;
      end
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      p = mk_pair(ax, ay, ac, 0, wa, ha, ax + dx, ay + dy, bc, 0, wb, hb);
    end else if (kind < 85) begin
      p = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      unit_axis(ac, an);
      unit_axis(bc, bn);
      p = mk_pair($urandom, $urandom, ac, an, $urandom, $urandom,
                  $urandom, $urandom, bc, bn, $urandom, $urandom);
    end
    return p;
  endfunction

  task automatic drive_pair(input box_pair_t p);
    boxes.center_a_x <= p.center_a_x;
    boxes.center_a_y <= p.center_a_y;
    boxes.dir_a_cos  <= p.dir_a_cos;
    boxes.dir_a_sin  <= p.dir_a_sin;
    boxes.width_a    <= p.width_a;
    boxes.height_a   <= p.height_a;
    boxes.center_b_x <= p.center_b_x;
    boxes.center_b_y <= p.center_b_y;
    boxes.dir_b_cos  <= p.dir_b_cos;
    boxes.dir_b_sin  <= p.dir_b_sin;
    boxes.width_b    <= p.width_b;
    boxes.height_b   <= p.height_b;
  endtask

  task automatic offer_pair(input box_pair_t p);
    int unsigned gap;
    bit          calm;
    calm = (pairs_sent >= 100 && pairs_sent < 160) || (pairs_sent >= 245 && pairs_sent < 330);
    gap  = (calm || $urandom_range(0, 1)) ? 0 : idle_len();
    if (gap > 0) begin
      boxes.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drive_pair(p);
    boxes.valid <= 1'b1;
    do @(posedge clk); while (boxes.ready !== 1'b1);
    sb.note_pair(p);
    pairs_sent++;
  endtask

  // result side: random stalls, one long hold-off to back the pipe up
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid === 1'b1 && result.ready === 1'b1)
        sb.check_result(result.overlapping);
      if (!hold_done && sb.checked == 250) begin
        hold_left = 80;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        if (!(sb.checked >= 100 && sb.checked < 160) && $urandom_range(0, 99) < 30)
          stall_left = idle_len();
      end
    end
  end

  initial begin
    box_pair_t cases[$];
    box_pair_t zero_pair;
    sb         = new();
    pairs_sent = 0;
    zero_pair  = mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rst         <= 1'b1;
    boxes.valid <= 1'b0;
    drive_pair(zero_pair);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // coincident, apart, exact contact, one lsb past contact
    cases.push_back(mk_pair(0, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16,
                            0, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16));
    cases.push_back(mk_pair(0, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16,
                            10 * ONE_Q16, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16));
    cases.push_back(mk_pair(0, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16,
                            2 * ONE_Q16, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16));
    cases.push_back(mk_pair(0, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16,
                            2 * ONE_Q16 + 1, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16));
    // quarter turn, contact along y and one lsb past contact
    cases.push_back(mk_pair(0, 0, 0, AXIS_ONE, 2 * ONE_Q16, 4 * ONE_Q16,
                            0, 2 * ONE_Q16, AXIS_ONE, 0, 4 * ONE_Q16, 2 * ONE_Q16));
    cases.push_back(mk_pair(0, 0, 0, -AXIS_ONE, 2 * ONE_Q16, 4 * ONE_Q16,
                            0, 2 * ONE_Q16 + 1, -AXIS_ONE, 0, 4 * ONE_Q16, 2 * ONE_Q16));
    // 45 degrees against aligned
    cases.push_back(mk_pair(0, 0, 11585, 11585, 2 * ONE_Q16, 2 * ONE_Q16,
                            (12 * ONE_Q16) / 5, 0, AXIS_ONE, 0, 2 * ONE_Q16, 2 * ONE_Q16));
    // degenerate sizes
    cases.push_back(mk_pair(ONE_Q16, ONE_Q16, AXIS_ONE, 0, 0, 0,
                            ONE_Q16, ONE_Q16, AXIS_ONE, 0, 0, 0));
    cases.push_back(mk_pair(ONE_Q16, ONE_Q16, AXIS_ONE, 0, 0, 0,
                            ONE_Q16 + 1, ONE_Q16, AXIS_ONE, 0, 0, 0));
    // zero axes: no axis can separate
    cases.push_back(mk_pair(COORD_MIN, 0, 0, 0, ONE_Q16, ONE_Q16,
                            COORD_MAX, 0, 0, 0, ONE_Q16, ONE_Q16));
    // axes outside the unit range
    cases.push_back(mk_pair(3 * ONE_Q16, -ONE_Q16, AX_MAX, AX_MIN, 5 * ONE_Q16, ONE_Q16,
                            -7 * ONE_Q16, 2 * ONE_Q16, AX_MIN, AX_MAX, ONE_Q16, 9 * ONE_Q16));
    cases.push_back(mk_pair(COORD_MAX, COORD_MIN, AX_MAX, AX_MAX, SIZE_MAX, SIZE_MAX,
                            COORD_MIN, COORD_MAX, AX_MIN, AX_MIN, SIZE_MAX, SIZE_MAX));
    // extreme centres
    cases.push_back(mk_pair(COORD_MIN, COORD_MIN, AXIS_ONE, 0, SIZE_MAX, SIZE_MAX,
                            COORD_MAX, COORD_MAX, AXIS_ONE, 0, SIZE_MAX, SIZE_MAX));
    cases.push_back(mk_pair(COORD_MAX, COORD_MAX, -AXIS_ONE, 0, 0, 0,
                            COORD_MIN, COORD_MIN, 0, -AXIS_ONE, 0, 0));
    cases.push_back(mk_pair(COORD_MAX, COORD_MAX, AX_MIN, AX_MIN, SIZE_MAX, SIZE_MAX,
                            COORD_MAX, COORD_MAX, AX_MIN, AX_MIN, SIZE_MAX, SIZE_MAX));
    cases.push_back(mk_pair(COORD_MIN, COORD_MAX, AX_MIN, 0, SIZE_MAX, 0,
                            COORD_MAX, COORD_MIN, 0, AX_MAX, 0, SIZE_MAX));
    // negated axes at contact
    cases.push_back(mk_pair(-ONE_Q16, 0, -AXIS_ONE, 0, 2 * ONE_Q16, 6 * ONE_Q16,
                            ONE_Q16, 0, -AXIS_ONE, 0, 2 * ONE_Q16, 6 * ONE_Q16));

    foreach (cases[i]) offer_pair(cases[i]);
    repeat (N_RANDOM) offer_pair(random_pair());

    // drop valid at the edge that took the last word
    boxes.valid <= 1'b0;
    while (sb.overlap_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** obb_overlap_test_2d: PASSED **");
    end else begin
      $display("** obb_overlap_test_2d: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/obb_pkg.sv
design/obb_box_if.sv
design/obb_res_if.sv
design/obb_mul_reg.sv
design/obb_overlap_test_2d.sv
bench/tb_obb_overlap_test_2d.sv
